// ===== design/tick_synced_gate_with_ramp_macros.svh =====
// Assertion macros shared by the gate design modules.
// Each macro wraps one clocked concurrent assertion with a reset disable.
`ifndef TICK_SYNCED_GATE_WITH_RAMP_MACROS_SVH
`define TICK_SYNCED_GATE_WITH_RAMP_MACROS_SVH

// Property holds at every edge outside reset.
`define TSG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tsg assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define TSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsg assertion failed");

`endif

// ===== design/tsg_pkg.sv =====
// Shared types and constants for the tick synced gate.
// No dependencies; imported by every gate module.
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int CFG_BITS    = 16;
  localparam int COUNT_BITS  = 17;

  localparam logic [CFG_BITS-1:0] GATE_LENGTH_RESET = 16'd2048;
  localparam logic [CFG_BITS-1:0] SLOPE_STEP_RESET  = 16'd4096;

  // Register index, taken from paddr[2]
  localparam logic REG_GATE_LENGTH = 1'b0;
  localparam logic REG_SLOPE_STEP  = 1'b1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ZERO,
    MODE_SCALE
  } mode_t;

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_t;

endpackage

`default_nettype wire

// ===== design/tsg_ctrl.sv =====
// Gate controller: sample counter, mute/ramp flags and gain ramp.
// Picks the per-sample mode for the lanes; uses tsg_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "tick_synced_gate_with_ramp_macros.svh"

module tsg_ctrl import tsg_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_en,
  input  wire logic                              tick_en,
  input  wire logic [CFG_BITS-1:0]               gate_length,
  input  wire logic [CFG_BITS-1:0]               slope_step,
  output mode_t                                  mode,
  output logic      [GAIN_FRAC_BITS+1:0]         gain
);

  localparam int GW    = GAIN_FRAC_BITS + 2;
  localparam int SH_UP = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
  localparam int SH_DN = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;
  localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;
  localparam logic [GW-1:0] GAIN_HI  = GW'(((64'd99 << GAIN_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [GW-1:0] GAIN_LO  = GW'(((64'd1 << GAIN_FRAC_BITS) + 64'd50) / 64'd100);

  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] sample_count_next;
  logic                  is_muted;
  logic                  is_muted_next;
  logic                  is_ramping;
  logic                  is_ramping_next;
  logic [GW-1:0]         gain_next;
  logic [GW-1:0]         step;
  logic [GW-1:0]         gain_up;
  logic [GW-1:0]         gain_dn;
  logic                  closing;

  assign step    = GW'(slope_step >> SH_DN) << SH_UP;
  assign gain_up = gain + step;
  assign gain_dn = (gain > step) ? gain - step : '0;
  assign closing = ({1'b0, sample_count} + 1'b1) == (COUNT_BITS + 1)'(gate_length);

  always_comb begin
    mode              = MODE_PASS;
    gain_next         = gain;
    is_muted_next     = is_muted;
    is_ramping_next   = is_ramping;
    sample_count_next = sample_count;
    if (tick_en) begin
      sample_count_next = '0;
      if (is_muted) begin
        is_muted_next   = 1'b0;
        is_ramping_next = 1'b1;
      end
    end else if (sample_en) begin
      if (sample_count != '1) begin
        sample_count_next = sample_count + 1'b1;
      end
      if (closing) begin
        // Finish an open up ramp on this sample, then start ramping down
        if (is_ramping && gain < GAIN_HI) begin
          mode      = MODE_SCALE;
          gain_next = gain_up;
        end
        is_muted_next   = 1'b1;
        is_ramping_next = !(gain_next <= GAIN_LO);
      end else if (!is_ramping) begin
        mode = is_muted ? MODE_ZERO : MODE_PASS;
      end else if (is_muted) begin
        if (gain > GAIN_LO) begin
          mode      = MODE_SCALE;
          gain_next = gain_dn;
        end else begin
          mode = MODE_ZERO;
        end
        is_ramping_next = !(gain_next <= GAIN_LO);
      end else begin
        if (gain < GAIN_HI) begin
          mode      = MODE_SCALE;
          gain_next = gain_up;
        end
        is_ramping_next = !(gain_next >= GAIN_HI);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      gain         <= GAIN_ONE;
      is_muted     <= 1'b0;
      is_ramping   <= 1'b0;
    end else begin
      sample_count <= sample_count_next;
      gain         <= gain_next;
      is_muted     <= is_muted_next;
      is_ramping   <= is_ramping_next;
    end
  end

  `TSG_ASSERT(a_gain_below_two, clk, rst, gain < (GAIN_ONE << 1))
  `TSG_ASSERT(a_closed_gain_low, clk, rst, !(is_muted && !is_ramping) || gain <= GAIN_LO)
  `TSG_ASSERT_NEXT(a_tick_clears_count, clk, rst, tick_en, sample_count == '0)

endmodule

`default_nettype wire

// ===== design/tsg_lane.sv =====
// One channel lane: registered gain multiply, round half up, saturate.
// Selects scaled, passed or zero sample by mode; uses tsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsg_lane import tsg_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [GAIN_FRAC_BITS+1:0]     gain,
  input  wire mode_t                         mode,
  output logic signed [SAMPLE_BITS-1:0]      result
);

  localparam int GW = GAIN_FRAC_BITS + 2;
  localparam int PW = SAMPLE_BITS + GW + 1;
  localparam int RW = PW - GAIN_FRAC_BITS;
  localparam logic [PW-1:0] RND = PW'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          rounded;
  logic signed [RW-1:0]          shifted;
  logic [RW-SAMPLE_BITS:0]       top_bits;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] scaled;
  mode_t                         mode_q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= PW'(sample) * PW'($signed({1'b0, gain}));
      sample_q <= sample;
      mode_q   <= mode;
    end
  end

  assign rounded  = prod + $signed(RND);
  assign shifted  = rounded[PW-1:GAIN_FRAC_BITS];
  assign top_bits = shifted[RW-1:SAMPLE_BITS-1];

  always_comb begin
    if (&top_bits || ~|top_bits) begin
      scaled = shifted[SAMPLE_BITS-1:0];
    end else begin
      scaled = shifted[RW-1] ? S_MIN : S_MAX;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_SCALE: result = scaled;
      MODE_ZERO:  result = '0;
      default:    result = sample_q;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tick_synced_gate_with_ramp.sv =====
// A sample beat goes through the stage-1, lane product and output registers to out_*.
// One beat per cycle unless out_ready stalls; ticks update control, no output.
// The gain ramp update is a registered loop in the controller; the multiply
// is registered in each lane, and the output register merges both lanes.
// Reset (rst, synchronous): pipeline empty, gain at unity, gate open,
// gate_length 2048, slope_step 4096.
`timescale 1ns / 1ps
`default_nettype none
`include "tick_synced_gate_with_ramp_macros.svh"

module tick_synced_gate_with_ramp import tsg_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data
);

  localparam int GW = GAIN_FRAC_BITS + 2;

  logic [CFG_BITS-1:0] gate_length;
  logic [CFG_BITS-1:0] slope_step;
  logic                cfg_wr;

  logic                in_beat;
  logic                en1;
  logic                en2;
  logic                en3;
  logic                v1;
  logic                v2;

  mode_t               mode;
  logic [GW-1:0]       gain;

  mode_t                         mode1;
  logic [GW-1:0]                 gain1;
  logic signed [SAMPLE_BITS-1:0] left1;
  logic signed [SAMPLE_BITS-1:0] right1;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_length <= GATE_LENGTH_RESET;
      slope_step  <= SLOPE_STEP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GATE_LENGTH: gate_length <= pwdata[CFG_BITS-1:0];
        REG_SLOPE_STEP:  slope_step  <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GATE_LENGTH: prdata = {{(32-CFG_BITS){1'b0}}, gate_length};
      REG_SLOPE_STEP:  prdata = {{(32-CFG_BITS){1'b0}}, slope_step};
      default:         prdata = '0;
    endcase
  end

  // Each stage loads when it is empty or the stage after it moves
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign in_beat  = in_valid && in_ready;

  tsg_ctrl #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .sample_en  (in_beat && in_data.func == FUNC_SAMPLE),
    .tick_en    (in_beat && in_data.func == FUNC_TICK),
    .gate_length(gate_length),
    .slope_step (slope_step),
    .mode       (mode),
    .gain       (gain)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      mode1  <= mode;
      gain1  <= gain;
      left1  <= in_data.left_in;
      right1 <= in_data.right_in;
    end
  end

  tsg_lane #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_left (
    .clk   (clk),
    .en    (en2),
    .sample(left1),
    .gain  (gain1),
    .mode  (mode1),
    .result(left_res)
  );

  tsg_lane #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_right (
    .clk   (clk),
    .en    (en2),
    .sample(right1),
    .gain  (gain1),
    .mode  (mode1),
    .result(right_res)
  );

  // Merge both lanes into the output beat
  always_ff @(posedge clk) begin
    if (en3) begin
      out_data.left_out  <= left_res;
      out_data.right_out <= right_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_beat && in_data.func == FUNC_SAMPLE;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  `TSG_ASSERT_NEXT(a_sample_enters, clk, rst, in_beat && in_data.func == FUNC_SAMPLE, v1)
  `TSG_ASSERT_NEXT(a_tick_no_result, clk, rst, in_beat && in_data.func == FUNC_TICK, !v1)
  `TSG_ASSERT(a_out_from_stage2, clk, rst, !$rose(out_valid) || $past(v2))

endmodule

`default_nettype wire
